[rtl/qsa_pkg.sv]
// Shared types and constants of the ready queue sort and aging unit.
package qsa_pkg;

    localparam int QSA_DEPTH_DEF = 16;
    localparam int PID_W         = 8;
    localparam int SCORE_W       = 16;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [2:0] {
        CMD_PUSH_TAIL = 3'd0,
        CMD_PUSH_HEAD = 3'd1,
        CMD_POP       = 3'd2,
        CMD_SORT      = 3'd3,
        CMD_AGE       = 3'd4,
        CMD_CLEAR     = 3'd5
    } t_cmd;

    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic [PID_W-1:0]       popped_pid;
        logic [SCORE_W-1:0]     popped_score;
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [SCORE_W-1:0]     head_score;
        logic                   head_valid;
    } t_result;

endpackage

[rtl/qsa_mem.sv]
// Entry memory: one write port, one read port with registered read data.
module qsa_mem #(
    parameter int DEPTH = qsa_pkg::QSA_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  qsa_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output qsa_pkg::t_entry o_rdata
);
    import qsa_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/qsa_ctrl.sv]
// Command sequencer: ring pointers, count, sort and age walks over the entry memory.
module qsa_ctrl #(
    parameter int DEPTH = qsa_pkg::QSA_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  logic [2:0]                  i_command,
    input  logic [qsa_pkg::PID_W-1:0]   i_new_pid,
    input  logic [qsa_pkg::SCORE_W-1:0] i_new_score,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output qsa_pkg::t_result            o_res,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output qsa_pkg::t_entry             o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  qsa_pkg::t_entry             i_mem_rdata
);
    import qsa_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_PUT,
        S_AGE,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_RESULT
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_cmd, n_cmd;
    t_entry              r_new, n_new;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    t_entry              r_cur, n_cur;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    t_entry              r_popped, n_popped;
    logic [1:0]          r_status, n_status;
    logic [SCORE_W-1:0]  r_head_score, n_head_score;

    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [CW-1:0] i_nxt;
    logic [CW-1:0] j_nxt;

    // Logical slot k of the queue lives at (head + k) mod DEPTH.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(k);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign i_nxt    = r_i + 1'b1;
    assign j_nxt    = r_j + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_new        = r_new;
        n_head       = r_head;
        n_count      = r_count;
        n_i          = r_i;
        n_j          = r_j;
        n_cur        = r_cur;
        n_pend       = r_pend;
        n_pend_addr  = r_pend_addr;
        n_popped     = r_popped;
        n_status     = r_status;
        n_head_score = r_head_score;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_head;
        o_mem_wdata  = r_cur;
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd       = i_command;
                    n_new.pid   = i_new_pid;
                    n_new.score = i_new_score;
                    n_popped    = '0;
                    n_status    = STS_DONE;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_HEAD_RD;
                case (r_cmd)
                    CMD_PUSH_TAIL: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = STS_FULL;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = phys(r_head, r_count);
                            o_mem_wdata = r_new;
                            n_count     = r_count + 1'b1;
                        end
                    end
                    CMD_PUSH_HEAD: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = STS_FULL;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = head_dec;
                            o_mem_wdata = r_new;
                            n_head      = head_dec;
                            n_count     = r_count + 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (r_count == '0) begin
                            n_status = STS_EMPTY;
                        end else begin
                            o_mem_re = 1'b1;
                            n_state  = S_POP_WAIT;
                        end
                    end
                    CMD_SORT: begin
                        if (r_count >= CW'(2)) begin
                            o_mem_re = 1'b1;
                            n_i      = '0;
                            n_state  = S_SORT_LOAD;
                        end
                    end
                    CMD_AGE: begin
                        n_i     = '0;
                        n_pend  = 1'b0;
                        n_state = S_AGE;
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_POP_WAIT: begin
                n_popped = i_mem_rdata;
                n_head   = head_inc;
                n_count  = r_count - 1'b1;
                n_state  = S_HEAD_RD;
            end
            S_SORT_LOAD: begin
                // r_cur starts as the entry at position i and keeps the lowest score met in the inner pass.
                n_cur       = i_mem_rdata;
                n_j         = i_nxt;
                o_mem_re    = 1'b1;
                o_mem_raddr = phys(r_head, i_nxt);
                n_state     = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (r_cur.score > i_mem_rdata.score) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = phys(r_head, r_j);
                    o_mem_wdata = r_cur;
                    n_cur       = i_mem_rdata;
                end
                if (j_nxt < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = phys(r_head, j_nxt);
                    n_j         = j_nxt;
                end else begin
                    n_state = S_SORT_PUT;
                end
            end
            S_SORT_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = phys(r_head, r_i);
                o_mem_wdata = r_cur;
                n_i         = i_nxt;
                if ((i_nxt + 1'b1) < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = phys(r_head, i_nxt);
                    n_state     = S_SORT_LOAD;
                end else begin
                    n_state = S_HEAD_RD;
                end
            end
            S_AGE: begin
                // Reads run one entry ahead of the write-back.
                if (r_pend) begin
                    o_mem_we          = 1'b1;
                    o_mem_waddr       = r_pend_addr;
                    o_mem_wdata.pid   = i_mem_rdata.pid;
                    o_mem_wdata.score = (i_mem_rdata.score != '0) ?
                                        i_mem_rdata.score - 1'b1 : i_mem_rdata.score;
                end
                if (r_i < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = phys(r_head, r_i);
                    n_pend      = 1'b1;
                    n_pend_addr = phys(r_head, r_i);
                    n_i         = i_nxt;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_HEAD_RD;
                    end
                end
            end
            S_HEAD_RD: begin
                o_mem_re = 1'b1;
                n_state  = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                n_head_score = (r_count != '0) ? i_mem_rdata.score : '0;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_cmd        <= n_cmd;
        r_new        <= n_new;
        r_i          <= n_i;
        r_j          <= n_j;
        r_cur        <= n_cur;
        r_pend_addr  <= n_pend_addr;
        r_popped     <= n_popped;
        r_status     <= n_status;
        r_head_score <= n_head_score;
    end

    assign o_cmd_ready        = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_RESULT);
    assign o_res.popped_pid   = r_popped.pid;
    assign o_res.popped_score = r_popped.score;
    assign o_res.status       = r_status;
    assign o_res.entry_count  = COUNT_OUT_W'(r_count);
    assign o_res.head_score   = r_head_score;
    assign o_res.head_valid   = (r_count != '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_RESULT) |-> !o_mem_we)
        else $error("memory written outside a command");

    a_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("read and write of one entry in the same cycle");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WAIT) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not remove one entry");

endmodule

[rtl/ready_queue_sort_and_aging_unit.sv]
// Ready queue of (process id, job score) entries held in a ring memory, with sort and aging.
// One command beat at a time. The pace of the sort and aging walks is set by the single entry
// memory, which can be read once and written once per cycle by the sequencer; the sort makes
// one compare per cycle. The result beat sits in an output register, so the next command is
// taken while a result still waits.
module ready_queue_sort_and_aging_unit #(
    parameter int QUEUE_DEPTH = qsa_pkg::QSA_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_command,
    input  logic [qsa_pkg::PID_W-1:0]           i_new_pid,
    input  logic [qsa_pkg::SCORE_W-1:0]         i_new_score,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [qsa_pkg::PID_W-1:0]           o_popped_pid,
    output logic [qsa_pkg::SCORE_W-1:0]         o_popped_score,
    output logic [1:0]                          o_status,
    output logic [qsa_pkg::COUNT_OUT_W-1:0]     o_entry_count,
    output logic [qsa_pkg::SCORE_W-1:0]         o_head_score,
    output logic                                o_head_valid
);
    import qsa_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          r_o_valid;
    t_result       r_o_res;

    qsa_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    qsa_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_valid),
        .o_cmd_ready (o_ready),
        .i_command   (i_command),
        .i_new_pid   (i_new_pid),
        .i_new_score (i_new_score),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // The output register frees up in the same cycle its beat is taken.
    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_o_res <= res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_popped_pid   = r_o_res.popped_pid;
    assign o_popped_score = r_o_res.popped_score;
    assign o_status       = r_o_res.status;
    assign o_entry_count  = r_o_res.entry_count;
    assign o_head_score   = r_o_res.head_score;
    assign o_head_valid   = r_o_res.head_valid;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ready queue sort and aging unit.
`timescale 1ns / 100ps

module tb_top;
    import qsa_pkg::*;

    class ready_queue_shadow #(int DEPTH = 16);
        t_entry  slots[DEPTH];
        int      fill;
        int      errors;
        t_result pending[$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Works out the result of one accepted command beat and queues it.
        function void take_command(logic [2:0] cmd, logic [PID_W-1:0] pid,
                                   logic [SCORE_W-1:0] score);
            t_result r;
            t_entry  tmp;
            int      i;
            int      j;
            r = '0;
            case (cmd)
                CMD_PUSH_TAIL: begin
                    if (fill >= DEPTH) begin
                        r.status = STS_FULL;
                    end else begin
                        slots[fill].pid   = pid;
                        slots[fill].score = score;
                        fill++;
                    end
                end
                CMD_PUSH_HEAD: begin
                    if (fill >= DEPTH) begin
                        r.status = STS_FULL;
                    end else begin
                        for (i = fill; i > 0; i--)
                            slots[i] = slots[i-1];
                        slots[0].pid   = pid;
                        slots[0].score = score;
                        fill++;
                    end
                end
                CMD_POP: begin
                    if (fill == 0) begin
                        r.status = STS_EMPTY;
                    end else begin
                        r.popped_pid   = slots[0].pid;
                        r.popped_score = slots[0].score;
                        for (i = 1; i < fill; i++)
                            slots[i-1] = slots[i];
                        fill--;
                    end
                end
                CMD_SORT: begin
                    for (i = 0; i < fill; i++) begin
                        for (j = i + 1; j < fill; j++) begin
                            if (slots[i].score > slots[j].score) begin
                                tmp      = slots[i];
                                slots[i] = slots[j];
                                slots[j] = tmp;
                            end
                        end
                    end
                end
                CMD_AGE: begin
                    for (i = 0; i < fill; i++)
                        if (slots[i].score != 0)
                            slots[i].score = slots[i].score - 1'b1;
                end
                CMD_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            r.entry_count = COUNT_OUT_W'(fill);
            r.head_valid  = (fill != 0);
            r.head_score  = (fill != 0) ? slots[0].score : '0;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [SCORE_W-1:0] want,
                                    logic [SCORE_W-1:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void match_outcome(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("result beat arrived with no command outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("popped_pid",   SCORE_W'(want.popped_pid),  SCORE_W'(got.popped_pid));
            compare_field("popped_score", want.popped_score,          got.popped_score);
            compare_field("status",       SCORE_W'(want.status),      SCORE_W'(got.status));
            compare_field("entry_count",  SCORE_W'(want.entry_count), SCORE_W'(got.entry_count));
            compare_field("head_score",   want.head_score,            got.head_score);
            compare_field("head_valid",   SCORE_W'(want.head_valid),  SCORE_W'(got.head_valid));
        endfunction
    endclass

    localparam int DEPTH = QSA_DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam int MODE_FILL = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX = 2;
    // Codes the block must treat as no-ops.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [2:0]             i_command;
    logic [PID_W-1:0]       i_new_pid;
    logic [SCORE_W-1:0]     i_new_score;
    logic                   o_valid;
    logic                   i_ready;
    logic [PID_W-1:0]       o_popped_pid;
    logic [SCORE_W-1:0]     o_popped_score;
    logic [1:0]             o_status;
    logic [COUNT_OUT_W-1:0] o_entry_count;
    logic [SCORE_W-1:0]     o_head_score;
    logic                   o_head_valid;

    int send_gap_pct;
    int recv_stall_pct;
    int quiet_cycles;

    ready_queue_shadow #(DEPTH) shadow;

    ready_queue_sort_and_aging_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_new_pid     (i_new_pid),
        .i_new_score   (i_new_score),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_popped_pid  (o_popped_pid),
        .o_popped_score(o_popped_score),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_head_score  (o_head_score),
        .o_head_valid  (o_head_valid)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.popped_pid   = o_popped_pid;
            got.popped_score = o_popped_score;
            got.status       = o_status;
            got.entry_count  = o_entry_count;
            got.head_score   = o_head_score;
            got.head_valid   = o_head_valid;
            shadow.match_outcome(got);
        end
    end

    // Long sorts and receiver stalls never come near this many silent cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_command(input logic [2:0] cmd, input logic [PID_W-1:0] pid,
                                input logic [SCORE_W-1:0] score);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_new_pid   <= pid;
        i_new_score <= score;
        do
            @(posedge i_clk);
        while (!o_ready);
        shadow.take_command(cmd, pid, score);
    endtask

    function automatic logic [2:0] random_command(int mode);
        int r;
        r = $urandom_range(99, 0);
        if (mode == MODE_FILL) begin
            if (r < 55)      return CMD_PUSH_TAIL;
            else if (r < 75) return CMD_PUSH_HEAD;
            else if (r < 82) return CMD_POP;
            else if (r < 88) return CMD_SORT;
            else if (r < 94) return CMD_AGE;
            else if (r < 96) return CMD_CLEAR;
            else if (r < 98) return CMD_SPARE_A;
            else             return CMD_SPARE_B;
        end else if (mode == MODE_DRAIN) begin
            if (r < 15)      return CMD_PUSH_TAIL;
            else if (r < 25) return CMD_PUSH_HEAD;
            else if (r < 70) return CMD_POP;
            else if (r < 80) return CMD_SORT;
            else if (r < 90) return CMD_AGE;
            else if (r < 94) return CMD_CLEAR;
            else if (r < 97) return CMD_SPARE_A;
            else             return CMD_SPARE_B;
        end else begin
            if (r < 25)      return CMD_PUSH_TAIL;
            else if (r < 40) return CMD_PUSH_HEAD;
            else if (r < 65) return CMD_POP;
            else if (r < 78) return CMD_SORT;
            else if (r < 90) return CMD_AGE;
            else if (r < 95) return CMD_CLEAR;
            else if (r < 97) return CMD_SPARE_A;
            else             return CMD_SPARE_B;
        end
    endfunction

    // Small scores give ties for the sort and hit zero under aging.
    function automatic logic [SCORE_W-1:0] random_score();
        int r;
        r = $urandom_range(5, 0);
        if (r < 2)       return SCORE_W'($urandom_range(3, 0));
        else if (r == 2) return ($urandom_range(1, 0) != 0) ? '1 : '0;
        else if (r == 3) return SCORE_W'($urandom_range(40, 0));
        else             return SCORE_W'($urandom);
    endfunction

    initial begin
        int phase;
        int sent;
        int burst;
        int mode;
        shadow         = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_PUSH_TAIL;
        i_new_pid      = '0;
        i_new_score    = '0;
        send_gap_pct   = 10;
        recv_stall_pct = 69;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Everything on an empty queue first, then extremes, then the rest.
        send_command(CMD_POP,       8'h12, 16'h3456);
        send_command(CMD_SORT,      8'hff, 16'hffff);
        send_command(CMD_AGE,       8'h00, 16'h0000);
        send_command(CMD_CLEAR,     8'h5a, 16'ha5a5);
        send_command(CMD_SPARE_A,   8'hff, 16'hffff);
        send_command(CMD_SPARE_B,   8'h00, 16'h0000);
        send_command(CMD_PUSH_TAIL, 8'h00, 16'h0000);
        send_command(CMD_PUSH_HEAD, 8'hff, 16'hffff);
        send_command(CMD_PUSH_TAIL, 8'haa, 16'h5555);
        send_command(CMD_PUSH_HEAD, 8'h55, 16'haaaa);
        send_command(CMD_PUSH_TAIL, 8'h01, 16'h0001);
        send_command(CMD_SPARE_A,   8'h00, 16'h0000);
        send_command(CMD_AGE,       8'h00, 16'h0000);
        send_command(CMD_SORT,      8'h00, 16'h0000);
        send_command(CMD_POP,       8'h00, 16'h0000);
        send_command(CMD_POP,       8'h00, 16'h0000);
        send_command(CMD_SPARE_B,   8'h00, 16'h0000);
        send_command(CMD_CLEAR,     8'h00, 16'h0000);
        send_command(CMD_POP,       8'h00, 16'h0000);

        sent = 0;
        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_gap_pct   = 69;
                recv_stall_pct = 10;
            end else if (phase == 2) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin
                burst = $urandom_range(30, 8);
                mode  = $urandom_range(MODE_MIX, MODE_FILL);
                repeat (burst) begin
                    send_command(random_command(mode), PID_W'($urandom), random_score());
                    sent++;
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (shadow.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
